@@ design/sht_pkg.sv @@
// ----------------------------------------------------------------------------
// SPI hash table package
// Operation codes shared by the table logic.
// ----------------------------------------------------------------------------
package sht_pkg;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_FLUSH  = 2'd3
   } op_type;

   localparam int SPI_W  = 32;
   localparam int PROTO_W = 2;
   localparam int SLOT_OUT_W = 8;

endpackage

@@ design/spi_hash_table_with_free_list.sv @@
// ----------------------------------------------------------------------------
// SPI hash table with free list
// Chained hash of (SPI, protocol) keys over a slot pool with a FIFO free list.
// ----------------------------------------------------------------------------
// Add fails at once with the pool empty and takes an extra link step when the
// bucket is not empty; search and delete walk the chain slot by slot, and a
// miss walks to its end; flush visits every bucket and frees each chained slot.
// One beat at a time: busy is high from accept until the result strobe, and
// the receiver cannot stall. Reset: a clearing pass over max(SLOTS,
// 2^BUCKET_BITS) addresses loads the free FIFO; busy stays high.
module spi_hash_table_with_free_list
   import sht_pkg::*;
#(
   parameter int SLOTS = 256,
   parameter int BUCKET_BITS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_op,
   input  logic [SPI_W-1:0]      req_spi_key,
   input  logic [PROTO_W-1:0]    req_proto_id,
   output logic                  rsp_valid,
   output logic                  rsp_ok,
   output logic [SLOT_OUT_W-1:0] rsp_slot
);

   localparam int SW = $clog2(SLOTS);   // slot index width
   localparam int PW = SW + 1;          // with the end/empty mark
   localparam int NB = 1 << BUCKET_BITS;
   localparam logic [PW-1:0] NIL = PW'(SLOTS);
   localparam int CLR_LAST = ((SLOTS > NB) ? SLOTS : NB) - 1;
   localparam int CW = $clog2(CLR_LAST + 1) + 1;

   typedef enum logic [10:0] {
      S_CLEAR  = 11'b00000000001,
      S_IDLE   = 11'b00000000010,
      S_BKT    = 11'b00000000100,
      S_BKTW   = 11'b00000001000,
      S_ADD    = 11'b00000010000,
      S_RD     = 11'b00000100000,
      S_CMP    = 11'b00001000000,
      S_DEL    = 11'b00010000000,
      S_FLRD   = 11'b00100000000,
      S_FLCMP  = 11'b01000000000,
      S_LINK   = 11'b10000000000
   } state_type;

   // memories
   logic [SPI_W-1:0]   spi_mem   [SLOTS];
   logic [PROTO_W-1:0] proto_mem [SLOTS];
   logic [PW-1:0]      next_mem  [SLOTS];
   logic [PW-1:0]      head_mem  [NB];
   logic [PW-1:0]      tail_mem  [NB];
   logic [SW-1:0]      free_mem  [SLOTS];

   state_type state_ff, state_in;
   logic [SW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0] count_ff, count_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [1:0]            op_ff;
   logic [SPI_W-1:0]      spi_ff;
   logic [PROTO_W-1:0]    proto_ff;
   logic [BUCKET_BITS-1:0] bkt_ff, bkt_in;
   logic [PW-1:0] cur_ff, cur_in, prev_ff, prev_in, tail_ff;
   logic [PW-1:0] steps_ff, steps_in;
   logic rv_ff, rv_in, rok_ff, rok_in;
   logic [SLOT_OUT_W-1:0] rslot_ff, rslot_in;

   // registered read data
   logic [SPI_W-1:0]   spi_q;
   logic [PROTO_W-1:0] proto_q;
   logic [PW-1:0]      next_q, head_q, tail_q;
   logic [SW-1:0]      free_q;

   // write requests
   logic          head_we, tail_we, next_we, slot_we, free_we;
   logic [BUCKET_BITS-1:0] bk_wa;
   logic [PW-1:0] head_wd, tail_wd;
   logic [SW-1:0] next_wa, slot_wa, free_wa;
   logic [PW-1:0] next_wd;
   logic [SW-1:0] free_wd;

   logic [SW-1:0] free_wr_pos;
   logic [SW:0]   free_sum;
   assign free_sum = {1'b0, rd_ptr_ff} + count_ff[SW:0];
   assign free_wr_pos = (SLOTS == (1 << SW)) ? free_sum[SW-1:0] :
      ((free_sum >= (SW+1)'(SLOTS)) ? SW'(free_sum - (SW+1)'(SLOTS)) : free_sum[SW-1:0]);

   logic hit;
   assign hit = (spi_q == spi_ff) && (proto_q == proto_ff);
   logic cur_ok;
   assign cur_ok = (cur_ff < NIL) && (steps_ff < NIL);

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_ok = rok_ff;
   assign rsp_slot = rslot_ff;

   always_comb begin
      state_in = state_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      clr_in = clr_ff;
      bkt_in = bkt_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      steps_in = steps_ff;
      rv_in = 1'b0;
      rok_in = 1'b0;
      rslot_in = '0;
      head_we = 1'b0; tail_we = 1'b0; next_we = 1'b0; slot_we = 1'b0; free_we = 1'b0;
      bk_wa = bkt_ff; head_wd = NIL; tail_wd = NIL;
      next_wa = cur_ff[SW-1:0]; next_wd = NIL;
      slot_wa = free_q; free_wa = free_wr_pos; free_wd = cur_ff[SW-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            // sweep free FIFO with identity; buckets cleared as we pass
            free_we = (clr_ff < CW'(SLOTS));
            free_wa = clr_ff[SW-1:0];
            free_wd = clr_ff[SW-1:0];
            if (clr_ff < CW'(NB)) begin
               head_we = 1'b1; tail_we = 1'b1;
               bk_wa = clr_ff[BUCKET_BITS-1:0];
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff >= CW'(CLR_LAST)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               bkt_in = (req_op == OP_FLUSH) ? '0 : req_spi_key[BUCKET_BITS-1:0];
               state_in = S_BKT;
            end
         end
         S_BKT: state_in = S_BKTW;   // head/tail/free reads in flight
         S_BKTW: begin
            prev_in = NIL;
            cur_in = head_q;
            steps_in = '0;
            unique case (op_type'(op_ff))
               OP_ADD: begin
                  if (count_ff == '0) begin
                     rv_in = 1'b1;
                     state_in = S_IDLE;
                  end else state_in = S_ADD;
               end
               OP_FLUSH: state_in = S_FLRD;
               default: state_in = S_RD;
            endcase
         end
         S_ADD: begin
            slot_we = 1'b1; slot_wa = free_q;
            next_we = 1'b1; next_wa = free_q; next_wd = NIL;
            tail_we = 1'b1; tail_wd = PW'(free_q);
            rd_ptr_in = (rd_ptr_ff == SW'(SLOTS - 1)) ? '0 : rd_ptr_ff + 1'b1;
            count_in = count_ff - 1'b1;
            cur_in = PW'(free_q);
            rok_in = 1'b1;
            rslot_in = SLOT_OUT_W'(free_q);
            if (tail_ff >= NIL) begin
               head_we = 1'b1; head_wd = PW'(free_q);
               rv_in = 1'b1;
               state_in = S_IDLE;
            end else state_in = S_LINK;
         end
         S_LINK: begin
            // append behind the old tail
            next_we = 1'b1; next_wa = tail_ff[SW-1:0]; next_wd = cur_ff;
            rv_in = 1'b1; rok_in = 1'b1;
            rslot_in = SLOT_OUT_W'(cur_ff);
            state_in = S_IDLE;
         end
         S_RD: begin
            if (!cur_ok) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end else state_in = S_CMP;
         end
         S_CMP: begin
            if (hit) begin
               rv_in = 1'b1; rok_in = 1'b1;
               rslot_in = SLOT_OUT_W'(cur_ff);
               state_in = (op_ff == OP_DELETE) ? S_DEL : S_IDLE;
               if (op_ff == OP_DELETE) rv_in = 1'b0;
            end else begin
               prev_in = cur_ff;
               cur_in = next_q;
               steps_in = steps_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_DEL: begin
            if (prev_ff >= NIL) begin
               head_we = 1'b1; head_wd = next_q;
            end else begin
               next_we = 1'b1; next_wa = prev_ff[SW-1:0]; next_wd = next_q;
            end
            // tail update; the unlinked slot's next is rewritten on its next add
            if (tail_ff == cur_ff) begin
               tail_we = 1'b1; tail_wd = prev_ff;
            end
            if (count_ff < NIL) begin
               free_we = 1'b1;
               count_in = count_ff + 1'b1;
            end
            rv_in = 1'b1; rok_in = 1'b1;
            rslot_in = SLOT_OUT_W'(cur_ff);
            state_in = S_IDLE;
         end
         S_FLRD: begin
            if (!cur_ok) begin
               head_we = 1'b1; tail_we = 1'b1;
               if (bkt_ff == BUCKET_BITS'(NB - 1)) begin
                  rv_in = 1'b1; rok_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  bkt_in = bkt_ff + 1'b1;
                  state_in = S_BKT;
               end
            end else state_in = S_FLCMP;
         end
         S_FLCMP: begin
            if (count_ff < NIL) begin
               free_we = 1'b1;
               count_in = count_ff + 1'b1;
            end
            cur_in = next_q;
            steps_in = steps_ff + 1'b1;
            state_in = S_FLRD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rd_ptr_ff <= '0;
         count_ff <= NIL;
         clr_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         op_ff <= req_op;
         spi_ff <= req_spi_key;
         proto_ff <= req_proto_id;
      end
      if (state_ff == S_BKTW) begin
         tail_ff <= tail_q;
      end
      bkt_ff <= bkt_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      steps_ff <= steps_in;
      rok_ff <= rok_in;
      rslot_ff <= rslot_in;
   end

   // bucket memories: read at the selected bucket, written at bk_wa
   always_ff @(posedge clock) begin
      head_q <= head_mem[bkt_in];
      tail_q <= tail_mem[bkt_in];
      if (head_we) head_mem[bk_wa] <= head_wd;
      if (tail_we) tail_mem[bk_wa] <= tail_wd;
   end

   // slot store; read address is the next walk position
   always_ff @(posedge clock) begin
      spi_q <= spi_mem[cur_in[SW-1:0]];
      proto_q <= proto_mem[cur_in[SW-1:0]];
      next_q <= next_mem[cur_in[SW-1:0]];
      if (slot_we) begin
         spi_mem[slot_wa] <= spi_ff;
         proto_mem[slot_wa] <= proto_ff;
      end
      if (next_we) next_mem[next_wa] <= next_wd;
   end

   // free FIFO
   always_ff @(posedge clock) begin
      free_q <= free_mem[rd_ptr_ff];
      if (free_we) free_mem[free_wa] <= free_wd;
   end

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> busy) else $error("busy low outside idle");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NIL) else $error("free count overflow");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> state_ff == S_IDLE) else $error("result while busy");
   a_notok_zero: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rok_ff) |-> rslot_ff == '0) else $error("slot not zero on miss");
`endif

endmodule
